[hdl/assert_macros.svh]
// Assertion macros shared by the text renderer RTL.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is low.
`define TCBR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tcbr assertion failed");
// Next-cycle implication, disabled while reset is low.
`define TCBR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tcbr assertion failed");
`else
`define TCBR_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TCBR_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[hdl/tcbr_pkg.sv]
// Shared types and constants of the text column byte renderer.
// Used by the register block and by the top level; depends on nothing.
package tcbr_pkg;

    localparam int GLYPH_WIDTH_DEF  = 5;
    localparam int GLYPH_HEIGHT_DEF = 8;
    localparam int GLYPH_COUNT_DEF  = 96;
    localparam int MAX_CHARS_DEF    = 32;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] MODE_TEXT   = 2'd0;
    localparam logic [1:0] MODE_FONT   = 2'd1;
    localparam logic [1:0] MODE_RENDER = 2'd2;

    localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
    localparam logic [2:0] REG_FIRST_PAGE  = 3'd1;
    localparam logic [2:0] REG_BIT_OFFSET  = 3'd2;
    localparam logic [2:0] REG_INVERT      = 3'd3;
    localparam logic [2:0] REG_TEXT_LENGTH = 3'd4;

    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef struct packed {
        logic [7:0] origin_x;
        logic [2:0] first_page;
        logic [2:0] bit_offset;
        logic       invert;
        logic [5:0] text_length;
    } t_cfg;

endpackage

[hdl/tcbr_cfg.sv]
// APB-style register block of the text column byte renderer.
// Depends on tcbr_pkg for the register codes and the t_cfg struct.
module tcbr_cfg import tcbr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            case (reg_sel)
                REG_ORIGIN_X:    r_cfg.origin_x    <= pwdata[7:0];
                REG_FIRST_PAGE:  r_cfg.first_page  <= pwdata[2:0];
                REG_BIT_OFFSET:  r_cfg.bit_offset  <= pwdata[2:0];
                REG_INVERT:      r_cfg.invert      <= pwdata[0];
                REG_TEXT_LENGTH: r_cfg.text_length <= pwdata[5:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_ORIGIN_X:    prdata = {24'd0, r_cfg.origin_x};
            REG_FIRST_PAGE:  prdata = {29'd0, r_cfg.first_page};
            REG_BIT_OFFSET:  prdata = {29'd0, r_cfg.bit_offset};
            REG_INVERT:      prdata = {31'd0, r_cfg.invert};
            REG_TEXT_LENGTH: prdata = {26'd0, r_cfg.text_length};
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

[hdl/text_column_byte_renderer.sv]
// Top level of the text column byte renderer: four-stage pipeline around
// a text memory and a two-read-port font memory. Depends on tcbr_pkg,
// tcbr_cfg and assert_macros.svh.
//
// Usage: configure origin, first page, bit offset, invert and text length
// over the APB port while the block is idle. Each request on the input
// channel (i_in_valid, o_in_stall) is a text load, a font load or a render
// of one page/column byte. Every request gives exactly one result on the
// output channel (o_out_valid, i_out_stall); loads return zero.
// One request is accepted every cycle while the output is not stalled: the
// text memory is read in the second stage, both font bytes (current page
// and the spill from the page above) in the third through two read ports,
// and the result register is loaded in the fourth.
// While a result waits under i_out_stall the whole pipeline holds and
// o_in_stall is raised; it drops in the cycle the result is taken.
// Reset clears the registers and the pipeline; the text and font memories
// are not cleared and must be loaded before use.
`include "assert_macros.svh"
module text_column_byte_renderer import tcbr_pkg::*; #(
    parameter int GLYPH_WIDTH  = GLYPH_WIDTH_DEF,
    parameter int GLYPH_HEIGHT = GLYPH_HEIGHT_DEF,
    parameter int GLYPH_COUNT  = GLYPH_COUNT_DEF,
    parameter int MAX_CHARS    = MAX_CHARS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_mode,
    input  logic [11:0]           i_load_index,
    input  logic [7:0]            i_load_value,
    input  logic [2:0]            i_page,
    input  logic [7:0]            i_column,
    input  logic [7:0]            i_block_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [7:0]            o_block_out,
    output logic                  o_touched
);

    localparam int CELL_WIDTH  = GLYPH_WIDTH + 1;
    localparam int FONT_PAGES  = (GLYPH_HEIGHT + 7) / 8;
    localparam int GLYPH_BYTES = GLYPH_WIDTH * FONT_PAGES;
    localparam int FONT_DEPTH  = (GLYPH_COUNT + 1) * GLYPH_BYTES;
    localparam int FONT_AW     = $clog2(FONT_DEPTH);
    localparam int CHAR_AW     = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
    // Reciprocal of the cell width; exact floor division for 8-bit columns.
    localparam logic [16:0] RECIP = 17'((65536 + CELL_WIDTH - 1) / CELL_WIDTH);

    t_cfg cfg;

    tcbr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    logic [7:0] text_mem [MAX_CHARS];
    logic [7:0] font_mem [FONT_DEPTH];

    logic adv;
    assign adv        = !(o_out_valid && i_out_stall);
    assign o_in_stall = !adv;

    // Stage 0: window check and cell division.
    logic [6:0]  n_chars;
    logic [11:0] total_cols;
    logic [7:0]  rel_col;
    logic [23:0] prod;
    logic        hit0;

    always_comb begin
        n_chars    = ({1'b0, cfg.text_length} > 7'(MAX_CHARS)) ? 7'(MAX_CHARS)
                                                               : {1'b0, cfg.text_length};
        total_cols = 12'(12'(n_chars) * 12'(CELL_WIDTH)) - 12'd1;
        rel_col    = i_column - cfg.origin_x;
        prod       = 24'(rel_col) * 24'(RECIP);
        hit0       = (n_chars != 7'd0) && (i_column >= cfg.origin_x)
                     && (i_page >= cfg.first_page) && ({4'd0, rel_col} < total_cols);
    end

    logic        r_a_valid, r_b_valid, r_c_valid, r_out_valid;
    logic [1:0]  r_a_mode, r_b_mode, r_c_mode;
    logic [11:0] r_a_idx, r_b_idx;
    logic [7:0]  r_a_val, r_b_val;
    logic [7:0]  r_a_blk, r_b_blk, r_c_blk;
    logic        r_a_hit, r_b_hit, r_c_hit;
    logic [7:0]  r_a_rel, r_a_cell;
    logic [2:0]  r_a_rpage, r_b_rpage;
    logic [4:0]  r_b_cx;
    logic [7:0]  r_b_code;
    logic        r_c_gcol, r_c_cur_ok, r_c_prev_ok;
    logic [7:0]  r_c_f0, r_c_f1;
    logic [7:0]  r_out_block;
    logic        r_out_touched;

    // Stage A: column within cell, text memory access.
    logic [4:0] cx_a;
    assign cx_a = 5'(r_a_rel - 8'(16'(r_a_cell) * 16'(CELL_WIDTH)));

    // Stage B: glyph lookup and font addresses.
    logic [7:0]  glyph;
    logic [15:0] base, addr0, addr1;
    logic [2:0]  rpage_m1;
    logic        cur_ok_b, prev_ok_b;

    always_comb begin
        glyph     = r_b_code - CHAR_SPACE;
        if (16'(glyph) >= 16'(GLYPH_COUNT)) begin
            glyph = 8'(GLYPH_COUNT);
        end
        rpage_m1  = r_b_rpage - 3'd1;
        base      = 16'(16'(glyph) * 16'(GLYPH_BYTES));
        addr0     = base + 16'(16'(r_b_rpage) * 16'(GLYPH_WIDTH)) + 16'(r_b_cx);
        addr1     = base + 16'(16'(rpage_m1) * 16'(GLYPH_WIDTH)) + 16'(r_b_cx);
        cur_ok_b  = {1'b0, r_b_rpage} < 4'(FONT_PAGES);
        prev_ok_b = (r_b_rpage != 3'd0) && ({1'b0, rpage_m1} < 4'(FONT_PAGES));
    end

    // Stage C: shift, spill and inversion.
    logic [7:0]  src0, src1, acc;
    logic [15:0] w0, w1;

    always_comb begin
        if (r_c_gcol) begin
            src0 = cfg.invert ? ~r_c_f0 : r_c_f0;
            src1 = cfg.invert ? ~r_c_f1 : r_c_f1;
        end else if (cfg.invert) begin
            src0 = 8'hff;
            src1 = 8'hff;
        end else begin
            src0 = 8'h00;
            src1 = 8'h00;
        end
        // The upper byte of the shifted word is what spills into the next page.
        w0  = {8'h00, src0} << cfg.bit_offset;
        w1  = {8'h00, src1} << cfg.bit_offset;
        acc = (r_c_cur_ok ? w0[7:0] : 8'h00) | (r_c_prev_ok ? w1[15:8] : 8'h00);
        if (!r_c_hit || r_c_mode != MODE_RENDER) begin
            acc = 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid   <= i_in_valid;
            r_b_valid   <= r_a_valid;
            r_c_valid   <= r_b_valid;
            r_out_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_mode  <= i_mode;
            r_a_idx   <= i_load_index;
            r_a_val   <= i_load_value;
            r_a_blk   <= i_block_in;
            r_a_hit   <= hit0;
            r_a_rel   <= rel_col;
            r_a_cell  <= prod[23:16];
            r_a_rpage <= i_page - cfg.first_page;

            r_b_mode  <= r_a_mode;
            r_b_idx   <= r_a_idx;
            r_b_val   <= r_a_val;
            r_b_blk   <= r_a_blk;
            r_b_hit   <= r_a_hit;
            r_b_rpage <= r_a_rpage;
            r_b_cx    <= cx_a;

            r_c_mode    <= r_b_mode;
            r_c_blk     <= r_b_blk;
            r_c_hit     <= r_b_hit;
            r_c_gcol    <= 16'(r_b_cx) < 16'(GLYPH_WIDTH);
            r_c_cur_ok  <= cur_ok_b;
            r_c_prev_ok <= prev_ok_b;

            r_out_block   <= (r_c_mode == MODE_RENDER) ? (r_c_blk | acc) : 8'h00;
            r_out_touched <= acc != 8'h00;
        end
    end

    // Text memory: written and read in stage A, so accesses keep request order.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_code <= text_mem[r_a_cell[CHAR_AW-1:0]];
            if (r_a_valid && r_a_mode == MODE_TEXT && r_a_idx < 12'(MAX_CHARS)) begin
                text_mem[r_a_idx[CHAR_AW-1:0]] <= r_a_val;
            end
        end
    end

    // Font memory: written and read in stage B for the same reason.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c_f0 <= font_mem[addr0[FONT_AW-1:0]];
            r_c_f1 <= font_mem[addr1[FONT_AW-1:0]];
            if (r_b_valid && r_b_mode == MODE_FONT && 32'(r_b_idx) < FONT_DEPTH) begin
                font_mem[FONT_AW'(r_b_idx)] <= r_b_val;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_block_out = r_out_block;
    assign o_touched   = r_out_touched;

    `TCBR_ASSERT_IMP(a_touch_nonzero, i_clk, i_rst_n, o_out_valid && o_touched, o_block_out != 8'h00)
    `TCBR_ASSERT_NXT(a_miss_untouched, i_clk, i_rst_n, adv && r_c_valid && !r_c_hit, !o_touched)
    `TCBR_ASSERT_NXT(a_load_zero, i_clk, i_rst_n, adv && r_c_valid && r_c_mode != MODE_RENDER, o_block_out == 8'h00 && !o_touched)
    `TCBR_ASSERT_NXT(a_hold_pipe, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(r_c_valid) && $stable(r_b_valid))

endmodule
